// File: hw/rtl/bvm_pkg.sv
package bvm_pkg;

  // Field widths
  localparam int unsigned MvW    = 13;
  localparam int unsigned StepW  = 10;
  localparam int unsigned LevelW = 7;

  // Default history depth
  localparam int unsigned HistoryLenDef = 5;

  // Reset value of the history and the smoothed voltage
  localparam logic [MvW-1:0] ResetMv = 13'd4200;

  // Configuration register reset values
  localparam logic [MvW-1:0]   FullMvRst   = 13'd4200;
  localparam logic [MvW-1:0]   NormalMvRst = 13'd3000;
  localparam logic [MvW-1:0]   LowMvRst    = 13'd2700;
  localparam logic [StepW-1:0] StepMvRst   = 10'd150;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgFullMv   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNormalMv = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLowMv    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgStepMv   = 2'd3;

  // IIR filter: smoothed = floor((9*prev + sample) / 10)
  localparam int unsigned IirW      = MvW + 4;      // holds 10 * 8191
  localparam int unsigned IirDiv    = 10;
  localparam int unsigned IirShift  = IirW + 4;     // exact reciprocal for IirW-bit values
  localparam int unsigned IirRecipW = IirShift - 3;
  localparam logic [IirRecipW-1:0] IirRecip =
    IirRecipW'(((1 << IirShift) + IirDiv - 1) / IirDiv);

  // Level steps above low_mv
  localparam int unsigned LevelSteps = 9;
  localparam int unsigned ThrW       = MvW + 2;     // low_mv + 9 * step_mv
  localparam logic [LevelW-1:0] LevelFull = 7'd100;
  localparam logic [LevelW-1:0] LevelZero = 7'd0;

  typedef struct packed {
    logic [MvW-1:0]   full_mv;
    logic [MvW-1:0]   normal_mv;
    logic [MvW-1:0]   low_mv;
    logic [StepW-1:0] step_mv;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level_percent;
    logic              status_changed;
    logic              battery_status;
    logic [MvW-1:0]    average_mv;
  } result_t;

endpackage

// File: hw/rtl/bvm_filter.sv
module bvm_filter #(
  parameter int unsigned HISTORY_LEN = bvm_pkg::HistoryLenDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [bvm_pkg::MvW-1:0]  sample_mv_i,
  output logic [bvm_pkg::MvW-1:0]  hist_o [HISTORY_LEN]
);

  logic [bvm_pkg::MvW-1:0] smoothed_q, smoothed_d;
  logic [bvm_pkg::MvW-1:0] hist_q [HISTORY_LEN];

  logic [bvm_pkg::IirW-1:0]                     acc;
  logic [bvm_pkg::IirW+bvm_pkg::IirRecipW-1:0]  prod;

  // 9*prev + sample, then divide by ten through the reciprocal
  always_comb begin
    acc = (bvm_pkg::IirW'(smoothed_q) << 3) + bvm_pkg::IirW'(smoothed_q)
        + bvm_pkg::IirW'(sample_mv_i);
    prod = (bvm_pkg::IirW+bvm_pkg::IirRecipW)'(acc)
         * (bvm_pkg::IirW+bvm_pkg::IirRecipW)'(bvm_pkg::IirRecip);
    smoothed_d = prod[bvm_pkg::IirShift +: bvm_pkg::MvW];
  end

  // Smoothed value and history shift on every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothed_q <= bvm_pkg::ResetMv;
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist_q[i] <= bvm_pkg::ResetMv;
      end
    end else if (load_i) begin
      smoothed_q <= smoothed_d;
      for (int i = 0; i < HISTORY_LEN - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HISTORY_LEN-1] <= smoothed_d;
    end
  end

  assign hist_o = hist_q;

endmodule

// File: hw/rtl/bvm_average.sv
module bvm_average #(
  parameter int unsigned HISTORY_LEN = bvm_pkg::HistoryLenDef
) (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic [bvm_pkg::MvW-1:0]  hist_i [HISTORY_LEN],
  output logic [bvm_pkg::MvW-1:0]  average_mv_o
);

  localparam int unsigned SumW     = bvm_pkg::MvW + $clog2(HISTORY_LEN);
  localparam int unsigned DivShift = SumW + $clog2(HISTORY_LEN);
  localparam int unsigned RecipW   = DivShift;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((1 << DivShift) + HISTORY_LEN - 1) / HISTORY_LEN);
  localparam int unsigned ProdW    = SumW + RecipW;

  logic [SumW-1:0]         sum;
  logic [ProdW-1:0]        prod;
  logic [bvm_pkg::MvW-1:0] average_q, average_d;

  // Sum of the history, divided by the depth through the reciprocal
  always_comb begin
    sum = '0;
    for (int i = 0; i < HISTORY_LEN; i++) begin
      sum = sum + SumW'(hist_i[i]);
    end
    prod      = ProdW'(sum) * ProdW'(Recip);
    average_d = prod[DivShift +: bvm_pkg::MvW];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      average_q <= average_d;
    end
  end

  assign average_mv_o = average_q;

endmodule

// File: hw/rtl/bvm_classify.sv
module bvm_classify (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [bvm_pkg::MvW-1:0]  average_mv_i,
  input  bvm_pkg::cfg_t            cfg_i,
  input  logic                     out_valid_i,
  output bvm_pkg::result_t         result_o
);

  logic                         status_q, status_d;
  bvm_pkg::result_t             result_q, result_d;
  logic [bvm_pkg::ThrW-1:0]     thr [1:bvm_pkg::LevelSteps];
  logic [bvm_pkg::LevelW-1:0]   level;

  // Hysteresis and level from the average
  always_comb begin
    status_d = status_q;
    if (average_mv_i > cfg_i.normal_mv) begin
      status_d = 1'b0;
    end else if (average_mv_i < cfg_i.low_mv) begin
      status_d = 1'b1;
    end

    for (int k = 1; k <= bvm_pkg::LevelSteps; k++) begin
      thr[k] = bvm_pkg::ThrW'(cfg_i.low_mv)
             + bvm_pkg::ThrW'(cfg_i.step_mv) * bvm_pkg::ThrW'(k);
    end

    // Thresholds rise with k: the last one met is the highest
    level = bvm_pkg::LevelZero;
    for (int k = 1; k <= bvm_pkg::LevelSteps; k++) begin
      if (bvm_pkg::ThrW'(average_mv_i) >= thr[k]) begin
        level = bvm_pkg::LevelW'(10 * k);
      end
    end
    if (average_mv_i >= cfg_i.full_mv) begin
      level = bvm_pkg::LevelFull;
    end else if (average_mv_i <= cfg_i.low_mv) begin
      level = bvm_pkg::LevelZero;
    end

    result_d.average_mv     = average_mv_i;
    result_d.battery_status = status_d;
    result_d.status_changed = status_d ^ status_q;
    result_d.level_percent  = level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 1'b0;
    end else if (load_i) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

  // Held status matches the word waiting at the output
  a_status_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_q == result_q.battery_status))
    else $error("status register differs from output word");

  // Change flag compares against the status before the load
  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (result_q.status_changed == (result_q.battery_status ^ $past(status_q))))
    else $error("status_changed inconsistent with previous status");

  // Level is a multiple of ten up to one hundred
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (result_q.level_percent == 7'd0 || result_q.level_percent == 7'd10 ||
                     result_q.level_percent == 7'd20 || result_q.level_percent == 7'd30 ||
                     result_q.level_percent == 7'd40 || result_q.level_percent == 7'd50 ||
                     result_q.level_percent == 7'd60 || result_q.level_percent == 7'd70 ||
                     result_q.level_percent == 7'd80 || result_q.level_percent == 7'd90 ||
                     result_q.level_percent == 7'd100))
    else $error("level_percent out of range");

endmodule

// File: hw/rtl/battery_voltage_monitor_core.sv
// Battery voltage monitor.
// Input stream (s_axis): one voltage sample word per transfer, sample_mv in
// tdata[12:0]. Output stream (m_axis): one result word per sample with the
// five-entry average, hysteresis status, change flag and charge level.
// Pipeline: filter/history stage, averaging stage, classify/output register.
// After its sample is accepted, the result word is registered in the averaging
// register, then in the output register; throughput is one word per cycle while
// m_axis_tready does not stall the output, set by the combinational IIR update (a
// shift-add and one reciprocal multiply) that closes the loop on the smoothed value.
// Each stage holds its word until the next stage is free, so the block
// keeps accepting samples while a result waits, until all three stages are
// full; a stalled receiver then deasserts s_axis_tready.
// Reset clears the pipeline, sets the smoothed value and every history entry to
// 4200 mV, the status to normal, and the thresholds to their defaults. The user
// writes thresholds through cfg_we_i/cfg_idx_i/cfg_data_i (0 full_mv, 1 normal_mv,
// 2 low_mv, 3 step_mv) only while the block is idle; the block does not enforce it.
module battery_voltage_monitor_core #(
  parameter int unsigned HISTORY_LEN = bvm_pkg::HistoryLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [bvm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bvm_pkg::MvW-1:0]      cfg_data_i,
  // Sample stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // [12:0] sample_mv
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [12:0] average_mv, [13] battery_status, [14] status_changed,
  // [21:15] level_percent
  output logic [23:0]                  m_axis_tdata
);

  bvm_pkg::cfg_t           cfg_q;
  bvm_pkg::result_t        result;
  logic                    v1_q, v2_q, v3_q;
  logic                    rdy1, rdy2, rdy3;
  logic                    ld1, ld2, ld3;
  logic [bvm_pkg::MvW-1:0] hist [HISTORY_LEN];
  logic [bvm_pkg::MvW-1:0] average_mv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_mv   <= bvm_pkg::FullMvRst;
      cfg_q.normal_mv <= bvm_pkg::NormalMvRst;
      cfg_q.low_mv    <= bvm_pkg::LowMvRst;
      cfg_q.step_mv   <= bvm_pkg::StepMvRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bvm_pkg::CfgFullMv:   cfg_q.full_mv   <= cfg_data_i;
        bvm_pkg::CfgNormalMv: cfg_q.normal_mv <= cfg_data_i;
        bvm_pkg::CfgLowMv:    cfg_q.low_mv    <= cfg_data_i;
        bvm_pkg::CfgStepMv:   cfg_q.step_mv   <= cfg_data_i[bvm_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when it is empty or draining
  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign ld1  = s_axis_tvalid && rdy1;
  assign ld2  = v1_q && rdy2;
  assign ld3  = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  bvm_filter #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ld1),
    .sample_mv_i (s_axis_tdata[bvm_pkg::MvW-1:0]),
    .hist_o      (hist)
  );

  bvm_average #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_average (
    .clk_i        (clk_i),
    .load_i       (ld2),
    .hist_i       (hist),
    .average_mv_o (average_mv)
  );

  bvm_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ld3),
    .average_mv_i (average_mv),
    .cfg_i        (cfg_q),
    .out_valid_i  (v3_q),
    .result_o     (result)
  );

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {2'b00, result.level_percent, result.status_changed,
                          result.battery_status, result.average_mv};

endmodule
